// ===== rtl/mcfp_pkg.sv =====
// Motor command frame parser: shared types and constants.
// Frame codes, phase type and result record; no dependencies.
`default_nettype none

package mcfp_pkg;

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'hFB;
    localparam logic [BYTE_W-1:0] CMD_SPEED    = 8'hE7;
    localparam logic [BYTE_W-1:0] CMD_DISTANCE = 8'hE8;
    localparam logic [BYTE_W-1:0] CMD_MODE     = 8'hEA;
    localparam logic [BYTE_W-1:0] CMD_RESTORE  = 8'hEC;
    localparam logic [BYTE_W-1:0] CMD_HOME     = 8'hED;
    localparam logic [BYTE_W-1:0] CMD_START    = 8'hEE;
    localparam logic [BYTE_W-1:0] CMD_STOP     = 8'hEF;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_DEF_SPEED    = 2'd0;
    localparam logic [1:0] REG_DEF_DISTANCE = 2'd1;
    localparam logic [1:0] REG_DEF_MODE     = 2'd2;

    typedef enum logic [1:0] {
        PH_SYNC = 2'd0,
        PH_DATA = 2'd1,
        PH_CMD  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic              last_of_run;
        logic              restore_pulse;
        logic              home_pulse;
        logic [BYTE_W-1:0] speed_now;
        logic [BYTE_W-1:0] distance_now;
        logic [BYTE_W-1:0] mode_now;
        logic              run_now;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/motor_command_frame_parser_unit.sv =====
// Motor command frame parser: top level.
// Depends on mcfp_pkg for frame codes, phase type and result record.
//
//  channel   handshake                   payload
//  rx        i_rx_valid / o_rx_ready     i_rx_byte
//  tx        o_tx_valid / i_tx_ready     o_tx_byte, o_last_of_run, pulses, settings
//  config    APB write/read, pready=1    i_paddr, i_pwdata, o_prdata
//
// A received byte is held in the input register, where it is decoded, and
// its results land in a two-slot output buffer. Bytes that produce no result
// pass at one per cycle; a frame-ending byte that yields echo bytes (up to
// two) waits until slot b is free and slot a is empty or being taken on tx.
// A stall on tx holds the buffer and backs up into the input register.
// Synchronous active-low reset clears phase, settings, run flag and buffer.
`default_nettype none

module motor_command_frame_parser_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // receive channel
    input  wire logic                         i_rx_valid,
    output logic                              o_rx_ready,
    input  wire logic [mcfp_pkg::BYTE_W-1:0]  i_rx_byte,
    // echo channel
    output logic                              o_tx_valid,
    input  wire logic                         i_tx_ready,
    output logic [mcfp_pkg::BYTE_W-1:0]       o_tx_byte,
    output logic                              o_last_of_run,
    output logic                              o_restore_pulse,
    output logic                              o_home_pulse,
    output logic [mcfp_pkg::BYTE_W-1:0]       o_speed_now,
    output logic [mcfp_pkg::BYTE_W-1:0]       o_distance_now,
    output logic [mcfp_pkg::BYTE_W-1:0]       o_mode_now,
    output logic                              o_run_now,
    // configuration port
    input  wire logic                         i_psel,
    input  wire logic                         i_penable,
    input  wire logic                         i_pwrite,
    input  wire logic [mcfp_pkg::ADDR_W-1:0]  i_paddr,
    input  wire logic [mcfp_pkg::PDATA_W-1:0] i_pwdata,
    output logic [mcfp_pkg::PDATA_W-1:0]      o_prdata,
    output logic                              o_pready
);

    import mcfp_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0] r_def_speed;
    logic [BYTE_W-1:0] r_def_distance;
    logic [BYTE_W-1:0] r_def_mode;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // parser state
    t_phase            r_phase;
    t_phase            n_phase;
    logic [BYTE_W-1:0] r_held;
    logic [BYTE_W-1:0] n_held;
    logic [BYTE_W-1:0] r_speed;
    logic [BYTE_W-1:0] n_speed;
    logic [BYTE_W-1:0] r_distance;
    logic [BYTE_W-1:0] n_distance;
    logic [BYTE_W-1:0] r_mode;
    logic [BYTE_W-1:0] n_mode;
    logic              r_run;
    logic              n_run;

    // output buffer: slot a is shown on the ports, slot b waits behind it
    t_result           r_a;
    t_result           r_b;
    logic              r_a_valid;
    logic              r_b_valid;

    logic              frame_end;
    logic [1:0]        n_cnt;
    logic [BYTE_W-1:0] echo;
    logic              is_restore;
    logic              is_home;
    t_result           res0;
    t_result           res1;
    logic              pop;
    logic              out_free;
    logic              fire;
    logic              wr_en;
    logic [1:0]        reg_idx;

    // ---------------- configuration ----------------
    assign o_pready = 1'b1;
    assign reg_idx  = i_paddr[ADDR_W-1:2];
    assign wr_en    = i_psel & i_penable & i_pwrite & o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_speed    <= '0;
            r_def_distance <= '0;
            r_def_mode     <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DEF_SPEED:    r_def_speed    <= i_pwdata[BYTE_W-1:0];
                REG_DEF_DISTANCE: r_def_distance <= i_pwdata[BYTE_W-1:0];
                REG_DEF_MODE:     r_def_mode     <= i_pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        unique case (reg_idx)
            REG_DEF_SPEED:    o_prdata[BYTE_W-1:0] = r_def_speed;
            REG_DEF_DISTANCE: o_prdata[BYTE_W-1:0] = r_def_distance;
            REG_DEF_MODE:     o_prdata[BYTE_W-1:0] = r_def_mode;
            default:          o_prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign pop        = r_a_valid & i_tx_ready;
    assign out_free   = !r_a_valid || (i_tx_ready && !r_b_valid);
    assign fire       = r_in_valid && ((n_cnt == 2'd0) || out_free);
    assign o_rx_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // ---------------- phase next state ----------------
    always_comb begin
        frame_end = 1'b0;
        unique case (r_phase)
            PH_DATA: n_phase = PH_CMD;
            PH_CMD: begin
                n_phase   = PH_SYNC;
                frame_end = 1'b1;
            end
            default: n_phase = (r_in_byte == SYNC_BYTE) ? PH_DATA : PH_SYNC;
        endcase
    end

    // ---------------- command decode ----------------
    always_comb begin
        n_held     = (r_phase == PH_DATA) ? r_in_byte : r_held;
        n_speed    = r_speed;
        n_distance = r_distance;
        n_mode     = r_mode;
        n_run      = r_run;
        n_cnt      = 2'd0;
        echo       = '0;
        is_restore = 1'b0;
        is_home    = 1'b0;
        if (frame_end) begin
            unique case (r_in_byte)
                CMD_SPEED: begin
                    n_speed = r_held;
                    echo    = r_held;
                    n_cnt   = 2'd2;
                end
                CMD_DISTANCE: begin
                    n_distance = r_held;
                    echo       = r_held;
                    n_cnt      = 2'd2;
                end
                CMD_MODE: begin
                    n_mode = r_held;
                    echo   = r_held;
                    n_cnt  = 2'd2;
                end
                CMD_START: begin
                    n_run = 1'b1;
                    echo  = {{(BYTE_W-1){1'b0}}, 1'b1};
                    n_cnt = 2'd2;
                end
                CMD_STOP: begin
                    n_run = 1'b0;
                    n_cnt = 2'd2;
                end
                CMD_RESTORE: begin
                    n_speed    = r_def_speed;
                    n_distance = r_def_distance;
                    n_mode     = r_def_mode;
                    is_restore = 1'b1;
                    n_cnt      = 2'd1;
                end
                CMD_HOME: begin
                    is_home = 1'b1;
                    n_cnt   = 2'd1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        res0.tx_byte       = r_in_byte;
        res0.last_of_run   = (n_cnt == 2'd1);
        res0.restore_pulse = is_restore;
        res0.home_pulse    = is_home;
        res0.speed_now     = n_speed;
        res0.distance_now  = n_distance;
        res0.mode_now      = n_mode;
        res0.run_now       = n_run;
        res1               = res0;
        res1.tx_byte       = echo;
        res1.last_of_run   = 1'b1;
        res1.restore_pulse = 1'b0;
        res1.home_pulse    = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SYNC;
            r_held     <= '0;
            r_speed    <= '0;
            r_distance <= '0;
            r_mode     <= '0;
            r_run      <= 1'b0;
        end else if (fire) begin
            r_phase    <= n_phase;
            r_held     <= n_held;
            r_speed    <= n_speed;
            r_distance <= n_distance;
            r_mode     <= n_mode;
            r_run      <= n_run;
        end
    end

    // ---------------- output buffer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (fire && (n_cnt != 2'd0)) begin
            r_a_valid <= 1'b1;
            r_b_valid <= (n_cnt == 2'd2);
        end else if (pop) begin
            // advance slot b into slot a
            r_a_valid <= r_b_valid;
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && (n_cnt != 2'd0)) begin
            r_a <= res0;
            r_b <= res1;
        end else if (pop) begin
            r_a <= r_b;
        end
    end

    assign o_tx_valid      = r_a_valid;
    assign o_tx_byte       = r_a.tx_byte;
    assign o_last_of_run   = r_a.last_of_run;
    assign o_restore_pulse = r_a.restore_pulse;
    assign o_home_pulse    = r_a.home_pulse;
    assign o_speed_now     = r_a.speed_now;
    assign o_distance_now  = r_a.distance_now;
    assign o_mode_now      = r_a.mode_now;
    assign o_run_now       = r_a.run_now;

    // ---------------- assertions ----------------
    a_b_behind_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> r_a_valid)
        else $error("second echo slot valid without first");

    a_not_last_has_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !r_a.last_of_run) |-> r_b_valid)
        else $error("non-final echo byte without its follower");

    a_pulses_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> !(r_a.restore_pulse && r_a.home_pulse))
        else $error("restore and home pulse together");

    a_pair_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (n_cnt == 2'd2)) |=> (r_a_valid && r_b_valid))
        else $error("two-byte echo not loaded into buffer");

    a_phase_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_phase == PH_CMD)) |=> (r_phase == PH_SYNC))
        else $error("frame did not return to sync search");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for motor_command_frame_parser_unit: byte stream in, echo bytes out.
// Depends on mcfp_pkg for frame codes, phase type and the echo record.

module testbench;
    import mcfp_pkg::*;

    class echo_scoreboard;
        logic [BYTE_W-1:0] def_speed, def_distance, def_mode;
        t_phase            phase;
        logic [BYTE_W-1:0] held, speed, distance, mode;
        logic              run;
        t_result           echo_queue[$];
        int                mismatches;
        int                bytes_in;
        int                echoes_seen;

        function new();
            def_speed = '0; def_distance = '0; def_mode = '0;
            phase = PH_SYNC;
            held = '0; speed = '0; distance = '0; mode = '0; run = 1'b0;
            mismatches = 0; bytes_in = 0; echoes_seen = 0;
        endfunction

        function void set_default(logic [1:0] idx, logic [BYTE_W-1:0] val);
            case (idx)
                REG_DEF_SPEED:    def_speed = val;
                REG_DEF_DISTANCE: def_distance = val;
                REG_DEF_MODE:     def_mode = val;
                default: ;
            endcase
        endfunction

        function void push_echo(logic [BYTE_W-1:0] tx, logic last, logic rst, logic home);
            t_result r;
            r.tx_byte       = tx;
            r.last_of_run   = last;
            r.restore_pulse = rst;
            r.home_pulse    = home;
            r.speed_now     = speed;
            r.distance_now  = distance;
            r.mode_now      = mode;
            r.run_now       = run;
            echo_queue.push_back(r);
        endfunction

        // Advance the frame decoder by one accepted request byte.
        function void note_rx(logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] value;
            bit                known, two;
            bytes_in++;
            case (phase)
                PH_DATA: begin
                    held  = b;
                    phase = PH_CMD;
                end
                PH_CMD: begin
                    phase = PH_SYNC;
                    known = 1'b1;
                    two   = 1'b1;
                    value = '0;
                    case (b)
                        CMD_SPEED:    begin speed = held;    value = speed;    end
                        CMD_DISTANCE: begin distance = held; value = distance; end
                        CMD_MODE:     begin mode = held;     value = mode;     end
                        CMD_START:    begin run = 1'b1;      value = 8'd1;     end
                        CMD_STOP:     begin run = 1'b0;      value = 8'd0;     end
                        CMD_RESTORE: begin
                            speed    = def_speed;
                            distance = def_distance;
                            mode     = def_mode;
                            two      = 1'b0;
                        end
                        CMD_HOME: two = 1'b0;
                        default:  known = 1'b0;
                    endcase
                    if (known) begin
                        push_echo(b, !two, b == CMD_RESTORE, b == CMD_HOME);
                        if (two)
                            push_echo(value, 1'b1, 1'b0, 1'b0);
                    end
                end
                default: phase = (b == SYNC_BYTE) ? PH_DATA : PH_SYNC;
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] echo %0d: %s", $time, echoes_seen, what);
        endtask

        task check_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
        endtask

        task check_echo(t_result got);
            t_result want;
            echoes_seen++;
            if (echo_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected echo byte %02h", got.tx_byte));
            end else begin
                want = echo_queue.pop_front();
                check_field("tx_byte", got.tx_byte, want.tx_byte);
                check_field("last_of_run", got.last_of_run, want.last_of_run);
                check_field("restore_pulse", got.restore_pulse, want.restore_pulse);
                check_field("home_pulse", got.home_pulse, want.home_pulse);
                check_field("speed_now", got.speed_now, want.speed_now);
                check_field("distance_now", got.distance_now, want.distance_now);
                check_field("mode_now", got.mode_now, want.mode_now);
                check_field("run_now", got.run_now, want.run_now);
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_rx_valid = 1'b0;
    logic                 o_rx_ready;
    logic [BYTE_W-1:0]    i_rx_byte = '0;
    logic                 o_tx_valid;
    logic                 i_tx_ready = 1'b0;
    logic [BYTE_W-1:0]    o_tx_byte;
    logic                 o_last_of_run;
    logic                 o_restore_pulse;
    logic                 o_home_pulse;
    logic [BYTE_W-1:0]    o_speed_now;
    logic [BYTE_W-1:0]    o_distance_now;
    logic [BYTE_W-1:0]    o_mode_now;
    logic                 o_run_now;
    logic                 i_psel = 1'b0;
    logic                 i_penable = 1'b0;
    logic                 i_pwrite = 1'b0;
    logic [ADDR_W-1:0]    i_paddr = '0;
    logic [PDATA_W-1:0]   i_pwdata = '0;
    logic [PDATA_W-1:0]   o_prdata;
    logic                 o_pready;

    echo_scoreboard       sb = new();
    bit                   rx_gaps_on = 1'b1;
    bit                   tx_stalls_on = 1'b1;
    int                   settings_used = 0;
    logic [BYTE_W-1:0]    known_cmds[7] = '{CMD_SPEED, CMD_DISTANCE, CMD_MODE, CMD_RESTORE,
                                            CMD_HOME, CMD_START, CMD_STOP};

    motor_command_frame_parser_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .o_tx_valid      (o_tx_valid),
        .i_tx_ready      (i_tx_ready),
        .o_tx_byte       (o_tx_byte),
        .o_last_of_run   (o_last_of_run),
        .o_restore_pulse (o_restore_pulse),
        .o_home_pulse    (o_home_pulse),
        .o_speed_now     (o_speed_now),
        .o_distance_now  (o_distance_now),
        .o_mode_now      (o_mode_now),
        .o_run_now       (o_run_now),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20_000_000);
        $display("timeout with %0d echoes outstanding", sb.echo_queue.size());
        $display("FAILURE");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    initial begin
        int n;
        forever begin
            n = tx_stalls_on ? pick_gap() : 0;
            if (n > 0) begin
                i_tx_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_tx_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_tx_valid && i_tx_ready) begin
            got.tx_byte       = o_tx_byte;
            got.last_of_run   = o_last_of_run;
            got.restore_pulse = o_restore_pulse;
            got.home_pulse    = o_home_pulse;
            got.speed_now     = o_speed_now;
            got.distance_now  = o_distance_now;
            got.mode_now      = o_mode_now;
            got.run_now       = o_run_now;
            sb.check_echo(got);
        end
    end

    // Hold valid and payload until the request is taken; keep valid high when no gap follows.
    task send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = rx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        sb.note_rx(b);
    endtask

    task send_frame(input logic [BYTE_W-1:0] data, input logic [BYTE_W-1:0] cmd);
        send_byte(SYNC_BYTE);
        send_byte(data);
        send_byte(cmd);
    endtask

    task cfg_write(input logic [1:0] idx, input logic [BYTE_W-1:0] val);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= {{(PDATA_W-BYTE_W){1'b0}}, val};
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        sb.set_default(idx, val);
    endtask

    task write_defaults(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] d,
                        input logic [BYTE_W-1:0] m);
        cfg_write(REG_DEF_SPEED, s);
        cfg_write(REG_DEF_DISTANCE, d);
        cfg_write(REG_DEF_MODE, m);
        settings_used++;
    endtask

    // Drain pending echoes, then let any no-echo byte clear the input stage.
    task wait_idle();
        while (sb.echo_queue.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'h00;
        else if (r < 20)
            return 8'hFF;
        else if (r < 25)
            return SYNC_BYTE;
        else
            return BYTE_W'($urandom_range(0, 255));
    endfunction

    task run_random(input int quota);
        int sent;
        int r;
        logic [BYTE_W-1:0] cmd;
        sent = 0;
        while (sent < quota) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                cmd = ($urandom_range(0, 9) < 8) ? known_cmds[$urandom_range(0, 6)]
                                                 : BYTE_W'($urandom_range(0, 255));
                send_frame(pick_data(), cmd);
                sent += 3;
            end else if (r < 93) begin
                // stray byte, may be a lone sync that shifts the framing
                send_byte(pick_data());
            end else begin
                // broken frame: sync plus data only; the next byte sent is taken as its command
                send_byte(SYNC_BYTE);
                send_byte(pick_data());
                sent += 2;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_defaults(8'hA5, 8'h5A, 8'hC3);
        send_byte(8'h00);
        send_frame(8'hFF, CMD_SPEED);
        send_frame(SYNC_BYTE, CMD_DISTANCE);
        send_frame(8'h00, CMD_MODE);
        send_frame(8'h5A, CMD_START);
        send_frame(8'hA5, CMD_RESTORE);
        send_frame(8'h00, CMD_HOME);
        send_frame(8'h33, CMD_STOP);
        send_frame(8'h12, SYNC_BYTE);

        i_rx_valid <= 1'b0;
        wait_idle();
        rx_gaps_on   = 1'b0;
        tx_stalls_on = 1'b0;
        write_defaults(8'h00, 8'h00, 8'h00);
        run_random(110);

        i_rx_valid <= 1'b0;
        wait_idle();
        rx_gaps_on   = 1'b1;
        tx_stalls_on = 1'b1;
        write_defaults(8'hFF, 8'hFF, 8'hFF);
        run_random(110);

        i_rx_valid <= 1'b0;
        wait_idle();
        tx_stalls_on = 1'b0;
        write_defaults(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                       BYTE_W'($urandom_range(0, 255)));
        run_random(110);

        i_rx_valid <= 1'b0;
        wait_idle();
        tx_stalls_on = 1'b1;
        write_defaults(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                       BYTE_W'($urandom_range(0, 255)));
        run_random(110);

        i_rx_valid <= 1'b0;
        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("Drove %0d received bytes and checked %0d echo bytes", sb.bytes_in,
                 sb.echoes_seen);
        $display("across %0d default settings; %0d mismatches", settings_used, sb.mismatches);
        if (sb.mismatches == 0 && sb.echo_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== motor_command_frame_parser_unit.f =====
rtl/mcfp_pkg.sv
rtl/motor_command_frame_parser_unit.sv
tb/sv/testbench.sv
